/* src/bip_pkg.sv */
// bip_pkg: shared types, constants and lookup tables of the binaural panner
// no dependencies; used by the multiplier, the top level, the checker and the testbench
package bip_pkg;

	// shared multiplier operand and product widths
	localparam int MUL_AW = 45;
	localparam int MUL_BW = 18;
	localparam int MUL_PW = 63;

	// table index width (up to 64 gain points)
	localparam int TAB_IW = 6;

	// register reset values
	localparam logic [15:0] GAIN_SCALE_RST   = 16'd26214;
	localparam logic [14:0] OUTPUT_LIMIT_RST = 15'd32440;
	localparam logic [15:0] ITD_SCALE_RST    = 16'd20224;

	// sine polynomial and angle constants, Q16
	localparam logic [16:0] RAD_K  = 17'd102944;
	localparam logic [16:0] SIN_C3 = 17'd42334;
	localparam logic [16:0] SIN_C5 = 17'd5223;
	localparam logic [16:0] SIN_C7 = 17'd307;

	// dB to log2 conversion
	localparam logic [16:0] LOG2_K   = 17'd17416;
	localparam logic [20:0] EXP_BIAS = 21'd16512;
	localparam int          DB_BIAS  = 256;

	localparam logic [15:0] SAMPLE_MAX = 16'd32767;

	typedef enum logic [1:0] {
		CFG_GAIN_SCALE   = 2'd0,
		CFG_OUTPUT_LIMIT = 2'd1,
		CFG_ITD_SCALE    = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		EAR_LEFT  = 1'b0,
		EAR_RIGHT = 1'b1
	} ear_t;

	typedef struct packed {
		logic signed [15:0] mono_sample;
		logic [15:0]        azimuth;
	} mono_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
	} stereo_t;

	typedef struct packed {
		logic                     en;
		logic signed [MUL_AW-1:0] a;
		logic signed [MUL_BW-1:0] b;
	} mul_req_t;

	// per-ear gain in tenths of a dB, 15 degree spacing
	function automatic logic signed [8:0] ear_db(ear_t ear, logic [TAB_IW-1:0] idx);
		logic signed [8:0] v;
		v = 9'sd0;
		if (ear == EAR_RIGHT) begin
			case (idx)
				6'd1:  v = 9'sd27;
				6'd2:  v = 9'sd50;
				6'd3:  v = 9'sd75;
				6'd4:  v = 9'sd85;
				6'd5:  v = 9'sd93;
				6'd6:  v = 9'sd97;
				6'd7:  v = 9'sd77;
				6'd8:  v = 9'sd49;
				6'd9:  v = 9'sd20;
				6'd10: v = -9'sd15;
				6'd11: v = -9'sd35;
				6'd12: v = -9'sd50;
				6'd13: v = -9'sd65;
				6'd14: v = -9'sd90;
				6'd15: v = -9'sd120;
				6'd16: v = -9'sd130;
				6'd17: v = -9'sd130;
				6'd18: v = -9'sd120;
				6'd19: v = -9'sd110;
				6'd20: v = -9'sd105;
				6'd21: v = -9'sd80;
				6'd22: v = -9'sd50;
				6'd23: v = -9'sd25;
				default: v = 9'sd0;
			endcase
		end else begin
			case (idx)
				6'd1:  v = -9'sd25;
				6'd2:  v = -9'sd50;
				6'd3:  v = -9'sd80;
				6'd4:  v = -9'sd105;
				6'd5:  v = -9'sd110;
				6'd6:  v = -9'sd120;
				6'd7:  v = -9'sd130;
				6'd8:  v = -9'sd130;
				6'd9:  v = -9'sd120;
				6'd10: v = -9'sd90;
				6'd11: v = -9'sd65;
				6'd12: v = -9'sd50;
				6'd13: v = -9'sd35;
				6'd14: v = -9'sd15;
				6'd15: v = 9'sd20;
				6'd16: v = 9'sd49;
				6'd17: v = 9'sd77;
				6'd18: v = 9'sd97;
				6'd19: v = 9'sd93;
				6'd20: v = 9'sd85;
				6'd21: v = 9'sd75;
				6'd22: v = 9'sd50;
				6'd23: v = 9'sd27;
				default: v = 9'sd0;
			endcase
		end
		return v;
	endfunction

	// 2^(k/16) in Q16, k = 0..16
	function automatic logic [17:0] pow2_tab(logic [4:0] k);
		logic [17:0] v;
		case (k)
			5'd0:  v = 18'd65536;
			5'd1:  v = 18'd68438;
			5'd2:  v = 18'd71468;
			5'd3:  v = 18'd74632;
			5'd4:  v = 18'd77936;
			5'd5:  v = 18'd81386;
			5'd6:  v = 18'd84990;
			5'd7:  v = 18'd88752;
			5'd8:  v = 18'd92682;
			5'd9:  v = 18'd96785;
			5'd10: v = 18'd101070;
			5'd11: v = 18'd105545;
			5'd12: v = 18'd110218;
			5'd13: v = 18'd115098;
			5'd14: v = 18'd120194;
			5'd15: v = 18'd125515;
			5'd16: v = 18'd131072;
			default: v = 18'd131072;
		endcase
		return v;
	endfunction

endpackage

/* src/bip_stream_if.sv */
// bip_stream_if: valid/ready stream channel with a typed payload
// payload types come from bip_pkg
interface bip_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* src/binaural_ild_itd_panner_unit.sv */
// binaural_ild_itd_panner_unit: top level, sequencer around one shared multiplier
// depends on bip_pkg, bip_stream_if, bip_ram and bip_mul
//
//  channel  | dir | payload                    | transfer when
//  ---------+-----+----------------------------+----------------------------
//  mono     | in  | mono_sample, azimuth       | mono.valid & mono.ready
//  stereo   | out | left_out, right_out        | stereo.valid & stereo.ready
//  cfg      | in  | cfg_index, cfg_wdata       | cfg_we
//
// one item passes through the idle cycle that takes the transfer, 8 steps of
// half-delay math, 6 steps per ear and a load step, most of them through the one
// multiplier; the load step then writes the pair into the output register.
// the multiplier is the unit that sets the rate.
// mono.ready is high only while idle; a finished pair sits in the output
// register so the next item can start while it waits.
// the load step holds while the output register is still full, stalling the input.
// reset clears the delay line through per-entry valid bits, no clearing pass.
module binaural_ild_itd_panner_unit #(
	parameter int DELAY_DEPTH  = 32,
	parameter int TABLE_POINTS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	bip_stream_if.sink   mono,
	bip_stream_if.source stereo,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	localparam int AW     = $clog2(DELAY_DEPTH);
	localparam int CENTRE = DELAY_DEPTH / 2;
	localparam int PTW    = 16 + $clog2(TABLE_POINTS + 1);

	typedef enum logic [15:0] {
		S_IDLE = 16'b0000_0000_0000_0001,
		S_T2   = 16'b0000_0000_0000_0010,
		S_C1   = 16'b0000_0000_0000_0100,
		S_C2   = 16'b0000_0000_0000_1000,
		S_C3   = 16'b0000_0000_0001_0000,
		S_C4   = 16'b0000_0000_0010_0000,
		S_RAD  = 16'b0000_0000_0100_0000,
		S_HD   = 16'b0000_0000_1000_0000,
		S_HC   = 16'b0000_0001_0000_0000,
		S_DB   = 16'b0000_0010_0000_0000,
		S_EXP  = 16'b0000_0100_0000_0000,
		S_MAN  = 16'b0000_1000_0000_0000,
		S_GX   = 16'b0001_0000_0000_0000,
		S_GS   = 16'b0010_0000_0000_0000,
		S_SAT  = 16'b0100_0000_0000_0000,
		S_PUSH = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q, state_d;

	// configuration registers
	logic [15:0] gain_scale_q;
	logic [14:0] limit_q;
	logic [15:0] itd_scale_q;

	// per-item working registers
	logic                          ear_q;
	logic [AW-1:0]                 wp_q;
	logic [AW-1:0]                 wr_pos_q;
	logic [16:0]                   t_q;
	logic                          neg_q;
	logic [16:0]                   t2_q;
	logic [16:0]                   s_q;
	logic [AW-1:0]                 addr_l_q, addr_r_q;
	logic [AW-1:0]                 hmag_q;
	logic [bip_pkg::TAB_IW-1:0]    lo_q, hi_q;
	logic [15:0]                   w_q;
	logic [15:0]                   tap_q;
	logic                          tap_neg_q;
	logic                          rd_vld_q;
	logic [3:0]                    n_q;
	logic [17:0]                   base_q;
	logic signed [15:0]            left_q;
	logic signed [15:0]            right_q;
	logic                          out_vld_q;
	bip_pkg::stereo_t              out_q;
	logic [DELAY_DEPTH-1:0]        valid_q;

	logic                              accept;
	bip_pkg::mul_req_t                 mreq;
	logic signed [bip_pkg::MUL_PW-1:0] prod;
	logic [AW-1:0]                     raddr;
	logic [15:0]                       rdata;

	// azimuth folding and table position
	logic [16:0]          az_mag;
	logic                 az_neg;
	logic [PTW-1:0]       ptab;
	logic [bip_pkg::TAB_IW-1:0] lo_d, hi_d;

	// combinational datapath slices
	logic [16:0]         poly_p;
	logic [17:0]         itd_sum;
	logic [34:0]         h_full;
	logic [AW-1:0]       hmag_d;
	logic signed [AW+1:0] hs, al, ar;
	logic signed [8:0]   db_lo, db_hi;
	logic signed [9:0]   db_diff;
	logic signed [27:0]  u_s;
	logic [20:0]         e_v;
	logic [4:0]          e_idx;
	logic [17:0]         man_m;
	logic [31:0]         gain_sh;
	logic [31:0]         mag_full;
	logic [15:0]         mag;
	logic signed [15:0]  shaped;
	logic signed [15:0]  tap_raw;

	assign accept = mono.valid && mono.ready;
	assign mono.ready = (state_q == S_IDLE);
	assign stereo.valid = out_vld_q;
	assign stereo.data = out_q;

	// fold the angle into +-quarter turn
	always_comb begin
		if (mono.data.azimuth < 16'd16384) begin
			az_mag = {1'b0, mono.data.azimuth};
			az_neg = 1'b0;
		end else if (mono.data.azimuth <= 16'd32768) begin
			az_mag = 17'd32768 - {1'b0, mono.data.azimuth};
			az_neg = 1'b0;
		end else if (mono.data.azimuth <= 16'd49152) begin
			az_mag = {1'b0, mono.data.azimuth} - 17'd32768;
			az_neg = 1'b1;
		end else begin
			az_mag = 17'd65536 - {1'b0, mono.data.azimuth};
			az_neg = 1'b1;
		end
		ptab = PTW'(mono.data.azimuth) * PTW'(TABLE_POINTS);
		lo_d = bip_pkg::TAB_IW'(ptab >> 16);
		hi_d = (lo_d == bip_pkg::TAB_IW'(TABLE_POINTS - 1)) ? '0 : lo_d + 1'b1;
	end

	// datapath slices of the shared product
	always_comb begin
		poly_p  = '0;
		if (state_q == S_C2) begin
			poly_p = bip_pkg::SIN_C5 - prod[32:16];
		end else if (state_q == S_C3) begin
			poly_p = bip_pkg::SIN_C3 - prod[32:16];
		end else begin
			poly_p = bip_pkg::RAD_K - prod[32:16];
		end
		itd_sum = {1'b0, s_q} + {1'b0, prod[32:16]};

		// half delay, clamped so both taps stay in the line
		h_full = prod[62:28];
		hmag_d = (h_full > 35'(CENTRE - 1)) ? AW'(CENTRE - 1) : h_full[AW-1:0];
		hs = neg_q ? -$signed({2'b00, hmag_d}) : $signed({2'b00, hmag_d});
		al = $signed({2'b00, wr_pos_q}) - ((AW+2)'(CENTRE) + hs);
		ar = $signed({2'b00, wr_pos_q}) - ((AW+2)'(CENTRE) - hs);
		if (al < 0) al = al + (AW+2)'(DELAY_DEPTH);
		if (ar < 0) ar = ar + (AW+2)'(DELAY_DEPTH);

		// dB interpolation pieces
		db_lo   = bip_pkg::ear_db(bip_pkg::ear_t'(ear_q), lo_q);
		db_hi   = bip_pkg::ear_db(bip_pkg::ear_t'(ear_q), hi_q);
		db_diff = 10'(db_hi) - 10'(db_lo);
		u_s = ((28'(db_lo) + 28'(bip_pkg::DB_BIAS)) <<< 16) + $signed(prod[27:0]);

		// log2 exponent split into shift, table index and remainder
		e_v   = prod[40:20] - bip_pkg::EXP_BIAS;
		e_idx = {1'b0, e_v[15:12]};

		man_m   = base_q + prod[29:12];
		gain_sh = 32'(man_m) << n_q;

		// output saturation
		mag_full = prod[62:31];
		mag = (mag_full > 32'(bip_pkg::SAMPLE_MAX)) ? bip_pkg::SAMPLE_MAX : mag_full[15:0];
		if (mag > {1'b0, limit_q}) mag = {1'b0, limit_q};
		shaped = tap_neg_q ? -$signed(mag) : $signed(mag);

		tap_raw = rd_vld_q ? $signed(rdata) : 16'sd0;
	end

	// multiplier operand selection and next state
	always_comb begin
		mreq    = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_T2;
			end
			S_T2: begin
				mreq = '{1'b1, bip_pkg::MUL_AW'(t_q), bip_pkg::MUL_BW'(t_q)};
				state_d = S_C1;
			end
			S_C1: begin
				mreq = '{1'b1, bip_pkg::MUL_AW'(prod[32:16]), bip_pkg::MUL_BW'(bip_pkg::SIN_C7)};
				state_d = S_C2;
			end
			S_C2: begin
				mreq = '{1'b1, bip_pkg::MUL_AW'(t2_q), bip_pkg::MUL_BW'(poly_p)};
				state_d = S_C3;
			end
			S_C3: begin
				mreq = '{1'b1, bip_pkg::MUL_AW'(t2_q), bip_pkg::MUL_BW'(poly_p)};
				state_d = S_C4;
			end
			S_C4: begin
				mreq = '{1'b1, bip_pkg::MUL_AW'(t_q), bip_pkg::MUL_BW'(poly_p)};
				state_d = S_RAD;
			end
			S_RAD: begin
				mreq = '{1'b1, bip_pkg::MUL_AW'(t_q), bip_pkg::MUL_BW'(bip_pkg::RAD_K)};
				state_d = S_HD;
			end
			S_HD: begin
				mreq = '{1'b1, bip_pkg::MUL_AW'(itd_sum), bip_pkg::MUL_BW'(itd_scale_q)};
				state_d = S_HC;
			end
			S_HC: state_d = S_DB;
			S_DB: begin
				mreq = '{1'b1, bip_pkg::MUL_AW'(db_diff), bip_pkg::MUL_BW'(w_q)};
				state_d = S_EXP;
			end
			S_EXP: begin
				mreq = '{1'b1, bip_pkg::MUL_AW'(u_s), bip_pkg::MUL_BW'(bip_pkg::LOG2_K)};
				state_d = S_MAN;
			end
			S_MAN: begin
				mreq = '{1'b1,
					bip_pkg::MUL_AW'(bip_pkg::pow2_tab(e_idx + 5'd1) - bip_pkg::pow2_tab(e_idx)),
					bip_pkg::MUL_BW'(e_v[11:0])};
				state_d = S_GX;
			end
			S_GX: begin
				mreq = '{1'b1, bip_pkg::MUL_AW'(gain_sh[31:4]), bip_pkg::MUL_BW'(tap_q)};
				state_d = S_GS;
			end
			S_GS: begin
				mreq = '{1'b1, bip_pkg::MUL_AW'(prod[44:0]), bip_pkg::MUL_BW'(gain_scale_q)};
				state_d = S_SAT;
			end
			S_SAT: state_d = (ear_q == bip_pkg::EAR_LEFT) ? S_DB : S_PUSH;
			S_PUSH: begin
				if (!out_vld_q || stereo.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign raddr = (ear_q == bip_pkg::EAR_RIGHT) ? addr_r_q : addr_l_q;

	bip_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	bip_ram #(
		.WIDTH (16),
		.DEPTH (DELAY_DEPTH)
	) u_line (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (mono.data.mono_sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wp_q         <= '0;
			valid_q      <= '0;
			out_vld_q    <= 1'b0;
			ear_q        <= bip_pkg::EAR_LEFT;
			gain_scale_q <= bip_pkg::GAIN_SCALE_RST;
			limit_q      <= bip_pkg::OUTPUT_LIMIT_RST;
			itd_scale_q  <= bip_pkg::ITD_SCALE_RST;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (bip_pkg::cfg_idx_t'(cfg_index))
					bip_pkg::CFG_GAIN_SCALE:   gain_scale_q <= cfg_wdata;
					bip_pkg::CFG_OUTPUT_LIMIT: limit_q      <= cfg_wdata[14:0];
					bip_pkg::CFG_ITD_SCALE:    itd_scale_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				valid_q[wp_q] <= 1'b1;
				wp_q <= (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				ear_q <= bip_pkg::EAR_LEFT;
			end
			if (state_q == S_SAT) ear_q <= bip_pkg::EAR_RIGHT;
			if (state_q == S_PUSH && (!out_vld_q || stereo.ready)) begin
				out_vld_q <= 1'b1;
			end else if (stereo.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			wr_pos_q <= wp_q;
			t_q      <= {az_mag[14:0], 2'b00};
			neg_q    <= az_neg;
			lo_q     <= lo_d;
			hi_q     <= hi_d;
			w_q      <= ptab[15:0];
		end
		if (state_q == S_C1) t2_q <= prod[32:16];
		if (state_q == S_RAD) s_q <= prod[32:16];
		if (state_q == S_HC) begin
			hmag_q   <= hmag_d;
			addr_l_q <= al[AW-1:0];
			addr_r_q <= ar[AW-1:0];
		end
		if (state_q == S_DB) rd_vld_q <= valid_q[raddr];
		if (state_q == S_EXP) begin
			tap_neg_q <= tap_raw[15];
			tap_q     <= tap_raw[15] ? 16'(-tap_raw) : tap_raw;
		end
		if (state_q == S_MAN) begin
			base_q <= bip_pkg::pow2_tab(e_idx);
			n_q    <= (e_v[20:16] > 5'd15) ? 4'd15 : e_v[19:16];
		end
		if (state_q == S_SAT && ear_q == bip_pkg::EAR_LEFT) left_q <= shaped;
		if (state_q == S_SAT && ear_q == bip_pkg::EAR_RIGHT) right_q <= shaped;
		// both ears load together so a waiting pair is never disturbed
		if (state_q == S_PUSH && (!out_vld_q || stereo.ready)) begin
			out_q <= '{left_out: left_q, right_out: right_q};
		end
	end

	// no new item while one is being worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !mono.ready)
		else $error("input taken while busy");

	// half delay always leaves both taps inside the line
	a_hmag_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DB) |-> (hmag_q <= AW'(CENTRE - 1)))
		else $error("half delay out of range");

	// output pair only appears from the load step
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_PUSH))
		else $error("output valid without load");

	// write pointer moves on every transfer in
	a_wp_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (wp_q != $past(wp_q)))
		else $error("write position stuck");
endmodule

/* src/bip_ram.sv */
// bip_ram: generic single write port, single read port RAM with registered read
// no dependencies
module bip_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* src/bip_mul.sv */
// bip_mul: shared signed multiplier with a registered product
// depends on bip_pkg for the request struct and widths
module bip_mul (
	input  logic                              clk,
	input  bip_pkg::mul_req_t                 req,
	output logic signed [bip_pkg::MUL_PW-1:0] prod
);
	logic signed [bip_pkg::MUL_PW-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= bip_pkg::MUL_PW'(req.a) * bip_pkg::MUL_PW'(req.b);
		end
	end

	assign prod = prod_q;
endmodule

/* dv/bip_panner_checker.sv */
`timescale 1ns / 1ps
// bip_panner_checker: watches the mono and stereo channels of the panner,
// predicts each stereo pair and compares it; depends on bip_pkg
module bip_panner_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        mono_valid,
	input  logic        mono_ready,
	input  bip_pkg::mono_t   mono_data,
	input  logic        stereo_valid,
	input  logic        stereo_ready,
	input  bip_pkg::stereo_t stereo_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output int          fail_count,
	output int          pending_pairs
);
	localparam int DEPTH = 32;
	localparam int POINTS = 24;

	logic signed [15:0] line_q [DEPTH];
	logic [4:0]         wpos_q;
	logic [15:0]        gscale_q;
	logic [14:0]        olimit_q;
	logic [15:0]        itd_q;
	bip_pkg::stereo_t   pair_q [$];

	function automatic logic [63:0] db_gain(longint signed db);
		logic [63:0] u, e, fr, idx, r, m;
		int unsigned n;
		if (db < -longint'(256) * 65536) db = -longint'(256) * 65536;
		if (db > longint'(256) * 65536) db = longint'(256) * 65536;
		u = db + longint'(256) * 65536;
		e = ((u * 17416) >> 20) - 16512;
		n = 32'(e >> 16);
		if (n > 15) n = 15;
		fr = e & 64'hFFFF;
		idx = fr >> 12;
		r = fr & 64'hFFF;
		m = 64'(bip_pkg::pow2_tab(idx[4:0])) + (((64'(bip_pkg::pow2_tab(idx[4:0] + 5'd1))
			- 64'(bip_pkg::pow2_tab(idx[4:0]))) * r) >> 12);
		return (m << n) >> 4;
	endfunction

	function automatic logic [63:0] ear_gain_of(bip_pkg::ear_t ear, logic [15:0] az);
		logic [31:0] p;
		int unsigned lo, hi;
		longint signed w, db;
		p = 32'(az) * 32'(POINTS);
		lo = (p >> 16) % POINTS;
		hi = (lo + 1) % POINTS;
		w = longint'(p & 32'hFFFF);
		db = longint'(bip_pkg::ear_db(ear, lo[5:0])) * (65536 - w)
			+ longint'(bip_pkg::ear_db(ear, hi[5:0])) * w;
		return db_gain(db);
	endfunction

	function automatic int half_itd(logic [15:0] az);
		int theta;
		logic [63:0] t, t2, p, s, rad, h;
		if (az < 16384) theta = int'(az);
		else if (az <= 49152) theta = 32768 - int'(az);
		else theta = int'(az) - 65536;
		t = 64'((theta < 0 ? -theta : theta) * 4);
		t2 = (t * t) >> 16;
		p = 5223 - ((t2 * 307) >> 16);
		p = 42334 - ((t2 * p) >> 16);
		p = 102944 - ((t2 * p) >> 16);
		s = (t * p) >> 16;
		rad = (t * 102944) >> 16;
		h = ((rad + s) * 64'(itd_q)) >> 28;
		if (h > 64'(DEPTH / 2 - 1)) h = 64'(DEPTH / 2 - 1);
		return theta < 0 ? -int'(h) : int'(h);
	endfunction

	function automatic logic [15:0] shaped(logic signed [15:0] x, logic [63:0] g);
		logic [63:0] mag, ax;
		ax = x < 0 ? -64'(x) : 64'(x);
		mag = (ax * g * 64'(gscale_q)) >> 31;
		if (mag > 32767) mag = 32767;
		if (mag > 64'(olimit_q)) mag = 64'(olimit_q);
		return x < 0 ? 16'(-mag) : mag[15:0];
	endfunction

	assign pending_pairs = pair_q.size();

	always_ff @(posedge clk or negedge arst_n) begin
		bip_pkg::stereo_t exp_pair, got;
		int       h;
		int       errs;
		logic [4:0] li, ri;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
			wpos_q <= '0;
			gscale_q <= bip_pkg::GAIN_SCALE_RST;
			olimit_q <= bip_pkg::OUTPUT_LIMIT_RST;
			itd_q <= bip_pkg::ITD_SCALE_RST;
			fail_count <= 0;
			pair_q.delete();
		end else begin
			errs = 0;
			if (cfg_we) begin
				case (bip_pkg::cfg_idx_t'(cfg_index))
					bip_pkg::CFG_GAIN_SCALE:   gscale_q <= cfg_wdata;
					bip_pkg::CFG_OUTPUT_LIMIT: olimit_q <= cfg_wdata[14:0];
					bip_pkg::CFG_ITD_SCALE:    itd_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (mono_valid && mono_ready) begin
				h = half_itd(mono_data.azimuth);
				li = wpos_q - 5'(DEPTH / 2 + h);
				ri = wpos_q - 5'(DEPTH / 2 - h);
				exp_pair.left_out = shaped(li == wpos_q ? mono_data.mono_sample : line_q[li],
					ear_gain_of(bip_pkg::EAR_LEFT, mono_data.azimuth));
				exp_pair.right_out = shaped(ri == wpos_q ? mono_data.mono_sample : line_q[ri],
					ear_gain_of(bip_pkg::EAR_RIGHT, mono_data.azimuth));
				pair_q.push_back(exp_pair);
				line_q[wpos_q] <= mono_data.mono_sample;
				wpos_q <= wpos_q + 5'd1;
			end
			if (stereo_valid && stereo_ready) begin
				got = stereo_data;
				if (pair_q.size() == 0) begin
					$error("unexpected stereo transfer %h", got);
					errs = errs + 1;
				end else begin
					exp_pair = pair_q.pop_front();
					if (got.left_out !== exp_pair.left_out) begin
						$error("left_out expected %0d actual %0d", exp_pair.left_out, got.left_out);
						errs = errs + 1;
					end
					if (got.right_out !== exp_pair.right_out) begin
						$error("right_out expected %0d actual %0d", exp_pair.right_out,
							got.right_out);
						errs = errs + 1;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end
endmodule

/* dv/tb_binaural_ild_itd_panner_unit.sv */
`timescale 1ns / 1ps
// tb_binaural_ild_itd_panner_unit: stimulus and verdict for the panner
// depends on bip_pkg, bip_stream_if, the block and bip_panner_checker
module tb_binaural_ild_itd_panner_unit;
	// directed sample and angle values: field extremes and fold boundaries
	localparam logic [15:0] SMP_DIR [8] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
		16'h0001, 16'h5555, 16'hAAAA, 16'h8001};
	localparam logic [15:0] AZ_DIR [12] = '{16'd0, 16'd16383, 16'd16384, 16'd16385,
		16'd32768, 16'd49152, 16'd49153, 16'd65535, 16'd2731, 16'd8192, 16'd40000, 16'hAAAA};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;
	int          fail_count;
	int          pending_pairs;
	int          cycle_count = 0;
	bit          hold_off;   // long receiver stall request

	bip_stream_if #(.T(bip_pkg::mono_t))   mono ();
	bip_stream_if #(.T(bip_pkg::stereo_t)) stereo ();

	binaural_ild_itd_panner_unit DUT (
		.clk(clk), .arst_n(arst_n), .mono(mono), .stereo(stereo),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	bip_panner_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.mono_valid(mono.valid), .mono_ready(mono.ready), .mono_data(mono.data),
		.stereo_valid(stereo.valid), .stereo_ready(stereo.ready), .stereo_data(stereo.data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending_pairs(pending_pairs)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit: ~1000 items with their random gaps and receiver stalls, many times over
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stall per pair, plus one long hold-off on request
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		stereo.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 13);
			if ($urandom_range(0, 3) == 0) gap = 0;
			repeat (gap) @(posedge clk);
			if (hold_off && !held) begin
				repeat (400) @(posedge clk);
				held = 1'b1;
			end
			stereo.ready <= 1'b1;
			@(posedge clk);
			while (!stereo.valid) @(posedge clk);
			stereo.ready <= 1'b0;
		end
	end

	// one mono transfer after a random gap; valid stays up for a back-to-back item
	task automatic send_sample(logic signed [15:0] smp, logic [15:0] az, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			mono.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mono.data <= '{mono_sample: smp, azimuth: az};
		mono.valid <= 1'b1;
		@(posedge clk);
		while (!mono.ready) @(posedge clk);
	endtask

	// registers change only once every pair has come out
	task automatic write_reg(bip_pkg::cfg_idx_t idx, logic [15:0] val);
		mono.valid <= 1'b0;
		@(posedge clk);
		while (pending_pairs != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] rand_az();
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(16000, 16800));
			1: return 16'($urandom_range(48800, 49500));
			2: return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2)) - 16'd1;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		hold_off = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bip_pkg::CFG_GAIN_SCALE;
		cfg_wdata = '0;
		mono.valid = 1'b0;
		mono.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, fold boundaries, wrap at a full turn
		for (int i = 0; i < 24; i++)
			send_sample(SMP_DIR[i % 8], AZ_DIR[i % 12], i > 12);

		// large itd saturates the half delay, limits at extremes
		write_reg(bip_pkg::CFG_ITD_SCALE, 16'hFFFF);
		write_reg(bip_pkg::CFG_GAIN_SCALE, 16'hFFFF);
		write_reg(bip_pkg::CFG_OUTPUT_LIMIT, 16'h7FFF);
		write_reg(bip_pkg::cfg_idx_t'(2'd3), 16'h1234);   // index beyond the list is ignored
		for (int i = 0; i < 12; i++) send_sample(SMP_DIR[i % 8], AZ_DIR[i], 1'b0);

		// random phases, each under its own register setting
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(bip_pkg::CFG_GAIN_SCALE, 16'd0);
					write_reg(bip_pkg::CFG_OUTPUT_LIMIT, 16'd0);
					write_reg(bip_pkg::CFG_ITD_SCALE, 16'd0);
				end
				1: begin
					write_reg(bip_pkg::CFG_GAIN_SCALE, 16'd32768);
					write_reg(bip_pkg::CFG_OUTPUT_LIMIT, 16'd32767);
					write_reg(bip_pkg::CFG_ITD_SCALE, 16'd20224);
				end
				2: write_reg(bip_pkg::CFG_OUTPUT_LIMIT, 16'h8000 | 16'($urandom_range(0, 32767)));
				default: begin
					write_reg(bip_pkg::CFG_GAIN_SCALE, 16'($urandom));
					write_reg(bip_pkg::CFG_OUTPUT_LIMIT, 16'($urandom));
					write_reg(bip_pkg::CFG_ITD_SCALE, 16'($urandom));
				end
			endcase
			// receiver stalls once for a long stretch while items keep coming
			if (ph == 3) hold_off = 1'b1;
			for (int i = 0; i < 115; i++) begin
				send_sample(16'($urandom), rand_az(), ph == 3 || $urandom_range(0, 4) == 0);
			end
		end

		mono.valid <= 1'b0;
		@(posedge clk);
		while (pending_pairs != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

/* binaural_ild_itd_panner_unit.f */
src/bip_pkg.sv
src/bip_stream_if.sv
src/bip_ram.sv
src/bip_mul.sv
src/binaural_ild_itd_panner_unit.sv
dv/bip_panner_checker.sv
dv/tb_binaural_ild_itd_panner_unit.sv
